FILE: design/rdn_pkg.sv
// ============================================================================
// rdn_pkg
// Shared constants, types and stage arithmetic for the 3D pixel denoiser.
// ============================================================================
package rdn_pkg;

    localparam int DEF_MAX_WIDTH = 4096;
    localparam int MAX_HEIGHT    = 4096;
    localparam int TABLE_DEPTH   = 512;
    localparam int TABLE_OFFSET  = 256;

    localparam int PIX_W  = 8;
    localparam int COEF_W = 9;
    localparam int TAB_AW = 9;
    localparam int SIZE_W = 13;
    localparam int ROW_W  = 12;   // row counter, MAX_HEIGHT - 1 fits
    localparam int HEFF_W = 13;   // effective height, MAX_HEIGHT fits
    localparam int REQ_W  = 2;

    localparam logic [REQ_W-1:0] REQ_PIXEL    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SPATIAL  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TEMPORAL = 2'd2;

    // APB register map: register index sits in paddr[2]
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;
    localparam logic [0:0] REG_WIDTH  = 1'b0;
    localparam logic [0:0] REG_HEIGHT = 1'b1;
    localparam logic [SIZE_W-1:0] RESET_WIDTH  = 13'd720;
    localparam logic [SIZE_W-1:0] RESET_HEIGHT = 13'd576;

    // output queue
    localparam int OUT_DEPTH = 4;
    localparam int OUT_AW    = 2;
    localparam int OUT_CW    = 3;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic [PIX_W-1:0] prev;
        logic             first_col;
        logic             first_row;
        logic             last;
    } t_pix_item;

    typedef struct packed {
        logic s1_full;
        logic busy;
    } t_pipe_stat;

    typedef struct packed {
        logic [PIX_W-1:0] filtered;
        logic             eof;
    } t_out_word;

    // table entry for prev - curr, offset into 0..511
    function automatic logic [TAB_AW-1:0] tab_index(input logic [PIX_W-1:0] prev,
                                                    input logic [PIX_W-1:0] curr);
        return {1'b0, prev} - {1'b0, curr} + TAB_AW'(TABLE_OFFSET);
    endfunction

    // curr + correction, saturated to 0..255
    function automatic logic [PIX_W-1:0] stage_sum(input logic [PIX_W-1:0] curr,
                                                   input logic signed [COEF_W-1:0] corr);
        logic signed [PIX_W+2:0] sum;
        sum = $signed({3'b000, curr}) + $signed({{2{corr[COEF_W-1]}}, corr});
        if (sum[PIX_W+2]) begin
            return '0;
        end else if (sum[PIX_W+1:PIX_W] != 2'b00) begin
            return '1;
        end else begin
            return sum[PIX_W-1:0];
        end
    endfunction

endpackage

FILE: design/rdn_cfg.sv
// ============================================================================
// rdn_cfg
// APB size registers with clamped effective width and height.
// ============================================================================
module rdn_cfg #(
    parameter int MAX_WIDTH = rdn_pkg::DEF_MAX_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rdn_pkg::APB_AW-1:0]        paddr,
    input  logic [rdn_pkg::APB_DW-1:0]        pwdata,
    output logic [rdn_pkg::APB_DW-1:0]        prdata,
    output logic                              pready,
    output logic [$clog2(MAX_WIDTH + 1)-1:0]  o_width_eff,
    output logic [rdn_pkg::HEFF_W-1:0]        o_height_eff,
    output logic                              o_restart
);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int EW = (WW > rdn_pkg::SIZE_W) ? WW : rdn_pkg::SIZE_W;

    logic [rdn_pkg::SIZE_W-1:0] r_width, r_height;
    logic                       w_wr;
    logic [0:0]                 w_idx;
    logic [EW-1:0]              w_wext;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[rdn_pkg::APB_AW-1];
    assign o_restart = w_wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= rdn_pkg::RESET_WIDTH;
            r_height <= rdn_pkg::RESET_HEIGHT;
        end else if (w_wr) begin
            case (w_idx)
                rdn_pkg::REG_WIDTH:  r_width  <= pwdata[rdn_pkg::SIZE_W-1:0];
                rdn_pkg::REG_HEIGHT: r_height <= pwdata[rdn_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            rdn_pkg::REG_WIDTH:  prdata = rdn_pkg::APB_DW'(r_width);
            rdn_pkg::REG_HEIGHT: prdata = rdn_pkg::APB_DW'(r_height);
            default:             prdata = '0;
        endcase
    end

    // zero reads as one, oversize clamps to the line store depth
    assign w_wext = EW'(r_width);
    always_comb begin
        if (r_width == '0) begin
            o_width_eff = WW'(1);
        end else if (w_wext > EW'(MAX_WIDTH)) begin
            o_width_eff = WW'(MAX_WIDTH);
        end else begin
            o_width_eff = WW'(w_wext);
        end
    end

    always_comb begin
        if (r_height == '0) begin
            o_height_eff = rdn_pkg::HEFF_W'(1);
        end else if (r_height > rdn_pkg::SIZE_W'(rdn_pkg::MAX_HEIGHT)) begin
            o_height_eff = rdn_pkg::HEFF_W'(rdn_pkg::MAX_HEIGHT);
        end else begin
            o_height_eff = rdn_pkg::HEFF_W'(r_height);
        end
    end

endmodule

FILE: design/rdn_tables.sv
// ============================================================================
// rdn_tables
// Spatial (two read ports) and temporal coefficient memories.
// ============================================================================
module rdn_tables (
    input  logic                               i_clk,
    input  logic                               i_we_sp,
    input  logic                               i_we_tp,
    input  logic [rdn_pkg::TAB_AW-1:0]         i_waddr,
    input  logic signed [rdn_pkg::COEF_W-1:0]  i_wdata,
    input  logic [rdn_pkg::TAB_AW-1:0]         i_sa_addr,
    output logic signed [rdn_pkg::COEF_W-1:0]  o_sa_data,
    input  logic [rdn_pkg::TAB_AW-1:0]         i_sb_addr,
    output logic signed [rdn_pkg::COEF_W-1:0]  o_sb_data,
    input  logic [rdn_pkg::TAB_AW-1:0]         i_t_addr,
    output logic signed [rdn_pkg::COEF_W-1:0]  o_t_data
);
    logic signed [rdn_pkg::COEF_W-1:0] r_spatial  [rdn_pkg::TABLE_DEPTH];
    logic signed [rdn_pkg::COEF_W-1:0] r_temporal [rdn_pkg::TABLE_DEPTH];
    logic signed [rdn_pkg::COEF_W-1:0] r_sa_q, r_sb_q, r_t_q;

    always_ff @(posedge i_clk) begin
        if (i_we_sp) begin
            r_spatial[i_waddr] <= i_wdata;
        end
        r_sa_q <= r_spatial[i_sa_addr];
        r_sb_q <= r_spatial[i_sb_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_we_tp) begin
            r_temporal[i_waddr] <= i_wdata;
        end
        r_t_q <= r_temporal[i_t_addr];
    end

    assign o_sa_data = r_sa_q;
    assign o_sb_data = r_sb_q;
    assign o_t_data  = r_t_q;

endmodule

FILE: design/rdn_pipe.sv
// ============================================================================
// rdn_pipe
// Six-stage filter pipe: horizontal, vertical, temporal stages, line store.
// ============================================================================
module rdn_pipe #(
    parameter int MAX_WIDTH = rdn_pkg::DEF_MAX_WIDTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_issue,
    input  rdn_pkg::t_pix_item                 i_item,
    input  logic [$clog2(MAX_WIDTH)-1:0]       i_col,
    output logic [rdn_pkg::TAB_AW-1:0]         o_sa_addr,
    input  logic signed [rdn_pkg::COEF_W-1:0]  i_sa_data,
    output logic [rdn_pkg::TAB_AW-1:0]         o_sb_addr,
    input  logic signed [rdn_pkg::COEF_W-1:0]  i_sb_data,
    output logic [rdn_pkg::TAB_AW-1:0]         o_t_addr,
    input  logic signed [rdn_pkg::COEF_W-1:0]  i_t_data,
    output logic                               o_push,
    output rdn_pkg::t_out_word                 o_word,
    output rdn_pkg::t_pipe_stat                o_stat
);
    localparam int CW = $clog2(MAX_WIDTH);

    logic [rdn_pkg::PIX_W-1:0] r_row [MAX_WIDTH];
    logic [rdn_pkg::PIX_W-1:0] r_row_q;
    logic [rdn_pkg::PIX_W-1:0] r_left;

    logic                 r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    rdn_pkg::t_pix_item   r_d1, r_d2, r_d3, r_d4, r_d5, r_d6;
    logic [CW-1:0]        r_c1, r_c2, r_c4, r_c5;
    logic [rdn_pkg::PIX_W-1:0] r_h3, r_up3, r_h4, r_a5, r_a6;
    logic [CW-1:0]        r_c3;

    logic [rdn_pkg::PIX_W-1:0] w_h, w_up, w_above;

    // stage 1: horizontal table lookup against the left neighbor
    assign o_sa_addr = rdn_pkg::tab_index(r_left, r_d1.pix);

    // stage 2: horizontal result; row above with bypass of writes in flight
    assign w_h = r_d2.first_col ? r_d2.pix : rdn_pkg::stage_sum(r_d2.pix, i_sa_data);

    always_comb begin
        if (r_v4 && (r_c4 == r_c2)) begin
            w_up = w_above;
        end else if (r_v5 && (r_c5 == r_c2)) begin
            w_up = r_a5;
        end else begin
            w_up = r_row_q;
        end
    end

    // stage 3: vertical lookup
    assign o_sb_addr = rdn_pkg::tab_index(r_up3, r_h3);

    // stage 4: vertical result, written back to the line store
    assign w_above = r_d4.first_row ? r_h4 : rdn_pkg::stage_sum(r_h4, i_sb_data);

    // stage 5: temporal lookup
    assign o_t_addr = rdn_pkg::tab_index(r_d5.prev, r_a5);

    // stage 6: temporal result
    assign o_push          = r_v6;
    assign o_word.filtered = rdn_pkg::stage_sum(r_a6, i_t_data);
    assign o_word.eof      = r_d6.last;

    assign o_stat.s1_full = r_v1;
    assign o_stat.busy    = r_v1 || r_v2 || r_v3 || r_v4 || r_v5 || r_v6;

    // line store: read-first, one read and one write per cycle
    always_ff @(posedge i_clk) begin
        r_row_q <= r_row[r_c1];
        if (r_v4) begin
            r_row[r_c4] <= w_above;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_v4   <= 1'b0;
            r_v5   <= 1'b0;
            r_v6   <= 1'b0;
            r_left <= '0;
        end else begin
            r_v1 <= i_issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            if (r_v2) begin
                r_left <= w_h;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_d1  <= i_item;
        r_c1  <= i_col;
        r_d2  <= r_d1;
        r_c2  <= r_c1;
        r_d3  <= r_d2;
        r_c3  <= r_c2;
        r_h3  <= w_h;
        r_up3 <= w_up;
        r_d4  <= r_d3;
        r_c4  <= r_c3;
        r_h4  <= r_h3;
        r_d5  <= r_d4;
        r_c5  <= r_c4;
        r_a5  <= w_above;
        r_d6  <= r_d5;
        r_a6  <= r_a5;
    end

endmodule

FILE: design/rdn_out_fifo.sv
// ============================================================================
// rdn_out_fifo
// Small result queue decoupling the pipe from the output stall.
// ============================================================================
module rdn_out_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  rdn_pkg::t_out_word i_word,
    output logic               o_valid,
    output rdn_pkg::t_out_word o_word,
    input  logic               i_stall
);
    rdn_pkg::t_out_word          r_mem [rdn_pkg::OUT_DEPTH];
    logic [rdn_pkg::OUT_AW-1:0]  r_wr, r_rd;
    logic [rdn_pkg::OUT_CW-1:0]  r_cnt, n_cnt;
    logic                        w_pop;

    assign o_valid = (r_cnt != '0);
    assign o_word  = r_mem[r_rd];
    assign w_pop   = o_valid && !i_stall;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && w_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

endmodule

FILE: design/recursive_3d_pixel_denoiser.sv
// ============================================================================
// recursive_3d_pixel_denoiser
// Recursive spatial/temporal denoiser for one image plane, raster order.
// ============================================================================
// Usage:
//  - Input channel (i_valid / o_stall): one word per pixel with the co-located
//    pixel of the previous filtered frame, or one coefficient table write.
//    Pixel words give exactly one result word, table writes and unused
//    request codes give none.
//  - Output channel (o_valid / i_stall): filtered pixel plus end-of-frame on
//    the last pixel of the plane. The host stores it as the next previous
//    frame pixel.
//  - An accepted pixel runs through the filter pipe into the result queue.
//  - Pixels are not taken back to back. The left-neighbor recursion runs
//    through the registered read of the spatial table and the add that
//    follows, before the next pixel may look up its own entry.
//  - Table writes are taken one per cycle once no pixel is in the pipe.
//  - Frame size is set over APB (width at 0x0, height at 0x4); a write
//    restarts the frame at its first pixel. Write only while idle.
//  - Reset clears the counters, left neighbor and result queue; it needs no
//    memory clearing pass. Tables must be loaded before pixels are sent.
//  - Output stall: results wait in a 4-word queue. Pixels are held off at
//    the input once every queue slot is spoken for, so nothing is dropped.
// ============================================================================
module recursive_3d_pixel_denoiser #(
    parameter int MAX_WIDTH = rdn_pkg::DEF_MAX_WIDTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input channel
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [rdn_pkg::REQ_W-1:0]          i_req_type,
    input  logic [rdn_pkg::PIX_W-1:0]          i_pixel,
    input  logic [rdn_pkg::PIX_W-1:0]          i_prev_pixel,
    input  logic [rdn_pkg::TAB_AW-1:0]         i_coef_index,
    input  logic signed [rdn_pkg::COEF_W-1:0]  i_coef_value,
    // output channel
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [rdn_pkg::PIX_W-1:0]          o_filtered,
    output logic                               o_end_of_frame,
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [rdn_pkg::APB_AW-1:0]         paddr,
    input  logic [rdn_pkg::APB_DW-1:0]         pwdata,
    output logic [rdn_pkg::APB_DW-1:0]         prdata,
    output logic                               pready
);
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int CRW = $clog2(rdn_pkg::OUT_DEPTH + 1);

    logic [WW-1:0]              w_width_eff;
    logic [rdn_pkg::HEFF_W-1:0] w_height_eff;
    logic                       w_restart;

    logic                       w_pix_req, w_tab_req, w_in_acc, w_pix_acc, w_out_acc;
    logic                       w_credit_full;
    logic                       w_col_wrap, w_row_wrap;
    rdn_pkg::t_pix_item         w_item;
    rdn_pkg::t_pipe_stat        w_stat;
    rdn_pkg::t_out_word         w_push_word, w_out_word;
    logic                       w_push;

    logic [rdn_pkg::TAB_AW-1:0]        w_sa_addr, w_sb_addr, w_t_addr;
    logic signed [rdn_pkg::COEF_W-1:0] w_sa_data, w_sb_data, w_t_data;

    logic [CW-1:0]              r_col, n_col;
    logic [rdn_pkg::ROW_W-1:0]  r_row, n_row;
    logic [CRW-1:0]             r_credit, n_credit;

    rdn_cfg #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_width_eff  (w_width_eff),
        .o_height_eff (w_height_eff),
        .o_restart    (w_restart)
    );

    // ---- input acceptance ----
    // A pixel needs an empty first stage (left-neighbor loop) and a free
    // result slot. A table write waits until no pixel still reads the tables.
    assign w_pix_req     = (i_req_type == rdn_pkg::REQ_PIXEL);
    assign w_tab_req     = (i_req_type == rdn_pkg::REQ_SPATIAL) ||
                           (i_req_type == rdn_pkg::REQ_TEMPORAL);
    assign w_credit_full = (r_credit == CRW'(rdn_pkg::OUT_DEPTH));
    assign o_stall       = (w_pix_req && (w_stat.s1_full || w_credit_full)) ||
                           (w_tab_req && w_stat.busy);
    assign w_in_acc      = i_valid && !o_stall;
    assign w_pix_acc     = w_in_acc && w_pix_req;
    assign w_out_acc     = o_valid && !i_stall;

    // ---- raster position ----
    assign w_col_wrap = (WW'(r_col) + WW'(1)) >= w_width_eff;
    assign w_row_wrap = (rdn_pkg::HEFF_W'(r_row) + rdn_pkg::HEFF_W'(1)) >= w_height_eff;

    assign w_item.pix       = i_pixel;
    assign w_item.prev      = i_prev_pixel;
    assign w_item.first_col = (r_col == '0);
    assign w_item.first_row = (r_row == '0);
    assign w_item.last      = w_col_wrap && w_row_wrap;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (w_restart) begin
            n_col = '0;
            n_row = '0;
        end else if (w_pix_acc) begin
            if (w_col_wrap) begin
                n_col = '0;
                n_row = w_row_wrap ? '0 : r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    // result slots spoken for: pixels in the pipe plus queued words
    always_comb begin
        n_credit = r_credit;
        if (w_pix_acc && !w_out_acc) begin
            n_credit = r_credit + 1'b1;
        end else if (!w_pix_acc && w_out_acc) begin
            n_credit = r_credit - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_credit <= '0;
        end else begin
            r_col    <= n_col;
            r_row    <= n_row;
            r_credit <= n_credit;
        end
    end

    // ---- coefficient tables, written straight from the input word ----
    rdn_tables u_tables (
        .i_clk     (i_clk),
        .i_we_sp   (w_in_acc && (i_req_type == rdn_pkg::REQ_SPATIAL)),
        .i_we_tp   (w_in_acc && (i_req_type == rdn_pkg::REQ_TEMPORAL)),
        .i_waddr   (i_coef_index),
        .i_wdata   (i_coef_value),
        .i_sa_addr (w_sa_addr),
        .o_sa_data (w_sa_data),
        .i_sb_addr (w_sb_addr),
        .o_sb_data (w_sb_data),
        .i_t_addr  (w_t_addr),
        .o_t_data  (w_t_data)
    );

    // ---- filter pipe with line store ----
    rdn_pipe #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_pipe (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_issue   (w_pix_acc),
        .i_item    (w_item),
        .i_col     (r_col),
        .o_sa_addr (w_sa_addr),
        .i_sa_data (w_sa_data),
        .o_sb_addr (w_sb_addr),
        .i_sb_data (w_sb_data),
        .o_t_addr  (w_t_addr),
        .i_t_data  (w_t_data),
        .o_push    (w_push),
        .o_word    (w_push_word),
        .o_stat    (w_stat)
    );

    // ---- result queue ----
    rdn_out_fifo u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_word  (w_push_word),
        .o_valid (o_valid),
        .o_word  (w_out_word),
        .i_stall (i_stall)
    );

    assign o_filtered     = w_out_word.filtered;
    assign o_end_of_frame = w_out_word.eof;

    // ---- assertions ----
    // left-neighbor loop: pixels never enter on consecutive cycles
    a_pix_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pix_acc |=> !w_pix_acc)
        else $error("pixels accepted back to back");

    // tables only change with no pixel left to read them
    a_tab_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_tab_req) |-> !w_stat.busy)
        else $error("table write while pipe busy");

    // slot count covers every queued word and never overruns the queue
    a_credit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_credit <= CRW'(rdn_pkg::OUT_DEPTH)) && (!o_valid || (r_credit != '0)))
        else $error("result slot count out of range");

endmodule

FILE: dv/denoiser_checker.sv
// ============================================================================
// denoiser_checker
// Tracks the frame geometry, the two correction tables, the line store and
// the left neighbor from the words accepted by the denoiser. It predicts each
// filtered pixel and compares the result channel with the predictions in
// order. It also checks register readback on the APB port.
// ============================================================================
module denoiser_checker
    import rdn_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // input channel, as seen at the block
    input  logic                     i_word_valid,
    input  logic                     i_word_stall,
    input  logic [REQ_W-1:0]         i_req_type,
    input  logic [PIX_W-1:0]         i_pixel,
    input  logic [PIX_W-1:0]         i_prev_pixel,
    input  logic [TAB_AW-1:0]        i_coef_index,
    input  logic signed [COEF_W-1:0] i_coef_value,
    // result channel
    input  logic                     i_res_valid,
    input  logic                     i_res_stall,
    input  logic [PIX_W-1:0]         i_filtered,
    input  logic                     i_end_of_frame,
    // APB
    input  logic                     i_psel,
    input  logic                     i_penable,
    input  logic                     i_pwrite,
    input  logic [APB_AW-1:0]        i_paddr,
    input  logic [APB_DW-1:0]        i_pwdata,
    input  logic [APB_DW-1:0]        i_prdata,
    input  logic                     i_pready,
    output int                       o_errors,
    output int                       o_pending
);

    logic [SIZE_W-1:0]        width_reg;
    logic [SIZE_W-1:0]        height_reg;
    logic [PIX_W-1:0]         left_pix;
    logic [PIX_W-1:0]         line_above [MAX_WIDTH];
    logic signed [COEF_W-1:0] spatial_corr [TABLE_DEPTH];
    logic signed [COEF_W-1:0] temporal_corr [TABLE_DEPTH];
    int                       col_pos;
    int                       row_pos;
    t_out_word                pixels_due [$];
    int                       errors = 0;
    int                       due_count = 0;

    assign o_errors  = errors;
    assign o_pending = due_count;

    // one recursion step: cur plus the correction picked by (ref - cur)
    function automatic logic [PIX_W-1:0] recurse(input logic [PIX_W-1:0] ref_pix,
                                                 input logic [PIX_W-1:0] cur,
                                                 input bit               temporal);
        int slot;
        int sum;
        slot = (int'(ref_pix) - int'(cur) + TABLE_OFFSET) & (TABLE_DEPTH - 1);
        if (temporal) begin
            sum = int'(cur) + int'(temporal_corr[slot]);
        end else begin
            sum = int'(cur) + int'(spatial_corr[slot]);
        end
        if (sum < 0) begin
            sum = 0;
        end else if (sum > 255) begin
            sum = 255;
        end
        return PIX_W'(sum);
    endfunction

    // horizontal, vertical, temporal; advances the raster position
    function automatic t_out_word filter_pixel(input logic [PIX_W-1:0] cur,
                                               input logic [PIX_W-1:0] prior);
        int               w;
        int               h;
        logic [PIX_W-1:0] above;
        t_out_word        res;
        w = int'(width_reg);
        h = int'(height_reg);
        if (w == 0) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        if (h == 0) h = 1;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;

        if (col_pos == 0) begin
            left_pix = cur;
        end else begin
            left_pix = recurse(left_pix, cur, 1'b0);
        end
        if (row_pos == 0) begin
            above = left_pix;
        end else begin
            above = recurse(line_above[col_pos], left_pix, 1'b0);
        end
        line_above[col_pos] = above;

        res.filtered = recurse(prior, above, 1'b1);
        res.eof      = 1'b0;
        if (col_pos + 1 >= w) begin
            col_pos = 0;
            if (row_pos + 1 >= h) begin
                row_pos = 0;
                res.eof = 1'b1;
            end else begin
                row_pos++;
            end
        end else begin
            col_pos++;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : track
        t_out_word        want;
        logic [SIZE_W-1:0] reg_val;
        if (!i_rst_n) begin
            width_reg  = RESET_WIDTH;
            height_reg = RESET_HEIGHT;
            left_pix   = '0;
            col_pos    = 0;
            row_pos    = 0;
            pixels_due.delete();
        end else begin
            if (i_psel && i_penable && i_pready) begin
                reg_val = (i_paddr[2] == REG_WIDTH) ? width_reg : height_reg;
                if (i_pwrite) begin
                    if (i_paddr[2] == REG_WIDTH) begin
                        width_reg = i_pwdata[SIZE_W-1:0];
                    end else begin
                        height_reg = i_pwdata[SIZE_W-1:0];
                    end
                    col_pos = 0;
                    row_pos = 0;
                end else if (i_prdata !== APB_DW'(reg_val)) begin
                    errors++;
                    $error("prdata: expected %0d, got %0d", reg_val, i_prdata);
                end
            end

            if (i_res_valid && !i_res_stall) begin
                if (pixels_due.size() == 0) begin
                    errors++;
                    $error("unexpected result word: filtered %0d end_of_frame %0b",
                           i_filtered, i_end_of_frame);
                end else begin
                    want = pixels_due.pop_front();
                    if (i_filtered !== want.filtered) begin
                        errors++;
                        $error("filtered: expected %0d, got %0d", want.filtered, i_filtered);
                    end
                    if (i_end_of_frame !== want.eof) begin
                        errors++;
                        $error("end_of_frame: expected %0b, got %0b", want.eof,
                               i_end_of_frame);
                    end
                end
            end

            if (i_word_valid && !i_word_stall) begin
                case (i_req_type)
                    REQ_PIXEL: begin
                        pixels_due.push_back(filter_pixel(i_pixel, i_prev_pixel));
                    end
                    REQ_SPATIAL: begin
                        spatial_corr[i_coef_index] = i_coef_value;
                    end
                    REQ_TEMPORAL: begin
                        temporal_corr[i_coef_index] = i_coef_value;
                    end
                    default: begin
                    end
                endcase
            end
        end
        due_count = pixels_due.size();
    end

endmodule

FILE: dv/testbench.sv
// ============================================================================
// testbench
// Drives the 3D pixel denoiser: loads both correction tables, runs a short
// directed list of corner words, then random pixel streams over a range of
// frame sizes, with random gaps on the input and random stalls on the output.
// Prediction and comparison live in denoiser_checker.
// ============================================================================
module testbench;
    import rdn_pkg::*;

    // Longest quiet stretch: a long output stall plus the pipe and the
    // idle pause around a register write. The limit leaves a wide margin.
    localparam int WATCHDOG_LIMIT = 5000;
    // random part; the table fill and the directed words make up the rest
    localparam int RANDOM_ITEMS   = 560;
    localparam int FIRST_RANDOM_PHASES = 10;
    // lets the pipe run dry after the last result, so table writes have landed too
    localparam int SETTLE_CYCLES  = 12;

    localparam logic [APB_AW-1:0]        ADDR_WIDTH  = {REG_WIDTH, 2'b00};
    localparam logic [APB_AW-1:0]        ADDR_HEIGHT = {REG_HEIGHT, 2'b00};
    localparam logic [REQ_W-1:0]         REQ_UNUSED  = 2'd3;
    localparam logic signed [COEF_W-1:0] CORR_MIN    = 9'h100;   // -256
    localparam logic signed [COEF_W-1:0] CORR_MAX    = 9'h0FF;   // +255

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;

    // input channel
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [REQ_W-1:0]         req_type = REQ_PIXEL;
    logic [PIX_W-1:0]         pixel = '0;
    logic [PIX_W-1:0]         prev_pixel = '0;
    logic [TAB_AW-1:0]        coef_index = '0;
    logic signed [COEF_W-1:0] coef_value = '0;

    // result channel
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [PIX_W-1:0]         filtered;
    logic                     end_of_frame;

    // APB
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [APB_AW-1:0]        paddr = '0;
    logic [APB_DW-1:0]        pwdata = '0;
    logic [APB_DW-1:0]        prdata;
    logic                     pready;

    int                       errors;
    int                       pending;      // pixels still owed a result word
    bit                       calm = 1'b0;  // no gaps, no stalls this phase
    int                       stall_run = 0;
    int                       idle_cycles = 0;

    recursive_3d_pixel_denoiser dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_valid        (in_valid),
        .o_stall        (in_stall),
        .i_req_type     (req_type),
        .i_pixel        (pixel),
        .i_prev_pixel   (prev_pixel),
        .i_coef_index   (coef_index),
        .i_coef_value   (coef_value),
        .o_valid        (out_valid),
        .i_stall        (out_stall),
        .o_filtered     (filtered),
        .o_end_of_frame (end_of_frame),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    denoiser_checker predictor_chk (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_word_valid   (in_valid),
        .i_word_stall   (in_stall),
        .i_req_type     (req_type),
        .i_pixel        (pixel),
        .i_prev_pixel   (prev_pixel),
        .i_coef_index   (coef_index),
        .i_coef_value   (coef_value),
        .i_res_valid    (out_valid),
        .i_res_stall    (out_stall),
        .i_filtered     (filtered),
        .i_end_of_frame (end_of_frame),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .i_prdata       (prdata),
        .i_pready       (pready),
        .o_errors       (errors),
        .o_pending      (pending)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Sender gap length: mostly none or a few cycles, now and then a long one.
    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm) return 0;
        if (roll < 55) return 0;
        if (roll < 94) return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    // Table content: mostly small corrections like a real strength curve,
    // a quarter anywhere in the full signed range.
    function automatic logic signed [COEF_W-1:0] pick_corr();
        if ($urandom_range(0, 3) == 0) return COEF_W'($urandom);
        return COEF_W'($urandom_range(0, 24) - 12);
    endfunction

    // Receiver: free and stalled stretches of random length. Each decision
    // holds until stall_run counts down, so stalls land on every pipe phase.
    always @(posedge clk) begin
        if (stall_run > 0) begin
            stall_run <= stall_run - 1;
        end else if (calm || $urandom_range(0, 2) != 0) begin
            out_stall <= 1'b0;
            stall_run <= $urandom_range(0, 5);
        end else begin
            out_stall <= 1'b1;
            stall_run <= ($urandom_range(0, 19) == 0) ? $urandom_range(12, 40)
                                                      : $urandom_range(0, 2);
        end
    end

    // Watchdog: cycles in which neither channel moves a word.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // One word on the input channel. Valid is only dropped when a gap is
    // taken, so back-to-back words keep it high with a single assignment.
    // Returns just after the edge that accepted the word.
    task automatic send_word(input logic [REQ_W-1:0]         req,
                             input logic [PIX_W-1:0]         pix,
                             input logic [PIX_W-1:0]         prior,
                             input logic [TAB_AW-1:0]        idx,
                             input logic signed [COEF_W-1:0] val);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= req;
        pixel      <= pix;
        prev_pixel <= prior;
        coef_index <= idx;
        coef_value <= val;
        do @(posedge clk); while (in_stall);
    endtask

    // Pixel word with junk in the ignored coefficient fields.
    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic [PIX_W-1:0] prior);
        send_word(REQ_PIXEL, pix, prior, TAB_AW'($urandom), COEF_W'($urandom));
    endtask

    // Table write with junk in the ignored pixel fields.
    task automatic send_corr(input logic [REQ_W-1:0]         req,
                             input logic [TAB_AW-1:0]        idx,
                             input logic signed [COEF_W-1:0] val);
        send_word(req, PIX_W'($urandom), PIX_W'($urandom), idx, val);
    endtask

    // Hold the input until every owed result word is out, then let the pipe
    // run dry (table writes give no result, so nothing else marks them done).
    // Pending is sampled on the falling edge, clear of the checker's update.
    task automatic drain();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Setup cycle, access cycle, then an idle cycle so psel is never
    // dropped and raised in the same step.
    task automatic apb_access(input bit                wr,
                              input logic [APB_AW-1:0] addr,
                              input logic [SIZE_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= APB_DW'(value);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // New frame geometry; a negative size leaves that register alone.
    // Both registers are read back afterwards.
    task automatic set_frame(input int w, input int h);
        drain();
        if (w >= 0) apb_access(1'b1, ADDR_WIDTH, SIZE_W'(w));
        if (h >= 0) apb_access(1'b1, ADDR_HEIGHT, SIZE_W'(h));
        apb_access(1'b0, ADDR_WIDTH, '0);
        apb_access(1'b0, ADDR_HEIGHT, '0);
    endtask

    initial begin
        int done_items;
        int phase;
        int quota;
        int roll;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values of the size registers
        apb_access(1'b0, ADDR_WIDTH, '0);
        apb_access(1'b0, ADDR_HEIGHT, '0);

        // Fill every entry of both tables before any pixel: reading an
        // unwritten entry is not defined.
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            send_corr(REQ_SPATIAL, TAB_AW'(i), pick_corr());
            send_corr(REQ_TEMPORAL, TAB_AW'(i), pick_corr());
        end

        // ---- directed corners, reset geometry (720 x 576) ----
        // difference table ends and the zero-difference entry at full scale,
        // so both saturation directions are reachable; pixel fields ignored
        send_word(REQ_SPATIAL, 8'hFF, 8'hFF, 9'd1, CORR_MIN);
        send_word(REQ_TEMPORAL, 8'hFF, 8'hFF, 9'd1, CORR_MIN);
        send_word(REQ_SPATIAL, 8'h00, 8'h00, 9'd256, CORR_MAX);
        send_word(REQ_TEMPORAL, 8'h00, 8'h00, 9'd256, CORR_MAX);
        send_word(REQ_SPATIAL, 8'h00, 8'h00, 9'd511, CORR_MAX);
        send_word(REQ_TEMPORAL, 8'hFF, 8'h00, 9'd511, CORR_MIN);
        send_word(REQ_TEMPORAL, 8'h00, 8'hFF, 9'd0, CORR_MAX);
        // first pixel: temporal stage only
        send_word(REQ_PIXEL, 8'h00, 8'h00, 9'd0, 9'h000);
        // largest difference against the left neighbor, on -256 entries: clips low; coef fields all ones
        send_word(REQ_PIXEL, 8'hFF, 8'hFF, 9'h1FF, 9'h1FF);
        // zero differences against the left neighbor, on the +255 entry
        send_word(REQ_PIXEL, 8'h00, 8'hFF, 9'h1FF, CORR_MIN);
        send_word(REQ_PIXEL, 8'hFF, 8'h00, 9'h000, CORR_MAX);
        // unused request code: no result
        send_word(REQ_UNUSED, 8'hFF, 8'hFF, 9'h1FF, 9'h1FF);
        send_word(REQ_UNUSED, 8'h00, 8'h00, 9'h000, 9'h000);
        send_pixel(8'd128, 8'd127);
        send_pixel(8'd1, 8'd254);
        // table write between pixels of the same row
        send_corr(REQ_SPATIAL, 9'd128, 9'sd0);
        send_pixel(8'd37, 8'd200);

        // ---- random streams over a run of frame geometries ----
        // The first write lands mid-row, which must restart the frame.
        // Every listed geometry runs at least once.
        done_items = 0;
        phase      = 0;
        while ((done_items < RANDOM_ITEMS) || (phase < FIRST_RANDOM_PHASES)) begin
            quota = $urandom_range(30, 90);
            case (phase)
                0: set_frame(1, 1);           // every pixel ends a frame
                1: set_frame(0, 0);           // zero sizes act as 1
                2: set_frame(2, 3);
                3: begin                      // oversize acts as 4096
                    set_frame(8191, 8191);
                    quota = 50;
                end
                4: begin                      // longest row
                    set_frame(4096, 1);
                    quota = 50;
                end
                5: begin                      // single column, vertical only
                    set_frame(1, 4096);
                    quota = 60;
                end
                6: set_frame(3, 0);
                7: set_frame(16, 6);
                8: set_frame(-1, 3);          // height alone restarts too
                9: set_frame(5, -1);          // and width alone
                default: begin
                    roll = $urandom_range(0, 9);
                    if (roll == 0) begin
                        set_frame($urandom_range(1, 12), -1);
                    end else if (roll == 1) begin
                        set_frame(-1, $urandom_range(1, 6));
                    end else begin
                        set_frame($urandom_range(1, 12), $urandom_range(1, 6));
                    end
                end
            endcase
            calm  <= ($urandom_range(0, 3) == 0);
            phase++;

            repeat (quota) begin
                roll = $urandom_range(0, 99);
                if (roll < 86) begin
                    send_pixel(PIX_W'($urandom), PIX_W'($urandom));
                    done_items++;
                end else if (roll < 93) begin
                    send_corr(roll[0] ? REQ_SPATIAL : REQ_TEMPORAL, TAB_AW'($urandom),
                              pick_corr());
                    done_items++;
                end else if (roll < 98) begin
                    send_word(REQ_UNUSED, PIX_W'($urandom), PIX_W'($urandom),
                              TAB_AW'($urandom), COEF_W'($urandom));
                end else begin
                    // hold off until the block has caught up completely
                    drain();
                end
            end
        end

        // let the last words through and give late extras a chance to show
        drain();
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/rdn_pkg.sv
design/rdn_cfg.sv
design/rdn_tables.sv
design/rdn_pipe.sv
design/rdn_out_fifo.sv
design/recursive_3d_pixel_denoiser.sv
dv/denoiser_checker.sv
dv/testbench.sv
